// File: hdl/pus_pkg.sv
// Shared types and constants for the scanline unfilter unit.
package pus_pkg;

  // Fixed widths of the stream fields and registers
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned WIDTH_W         = 13;
  localparam int unsigned POS_W           = 14;
  localparam int unsigned LEN_W           = POS_W + 1;
  localparam int unsigned BYTES_PER_PIXEL = 4;
  localparam int unsigned MAX_WIDTH_DEF   = 4096;

  // Filter-type codes of filter method 0
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  // Highest legal filter-type byte
  localparam logic [BYTE_W-1:0] MAX_FILTER = BYTE_W'(FILT_PAETH);

endpackage

// File: hdl/pus_in_if.sv
// Input stream channel: filtered bytes with image start marker.
interface pus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_byte;
  logic       new_image;

  modport source (output valid, output filtered_byte, output new_image, input ready);
  modport sink   (input valid, input filtered_byte, input new_image, output ready);
endinterface

// File: hdl/pus_out_if.sv
// Output stream channel: reconstructed bytes with line and error flags.
interface pus_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       end_of_line;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output end_of_line, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_byte, input end_of_line, input bad_filter,
                  output ready);
endinterface

// File: hdl/png_scanline_unfilter_unit.sv
// Top level: PNG scanline unfilter for 8-bit RGBA with a line store memory.
//
//  channel  dir  handshake       payload
//  in_i     in   valid/ready     filtered_byte[7:0], new_image
//  out_o    out  valid/ready     pixel_byte[7:0], end_of_line, bad_filter
//  cfg      in   cfg_we_i        cfg_wdata_i[12:0] = pixels per line
//
// One input byte is taken per cycle while the output side is not stalled; filter-type
// bytes give no result. The line store is read as a byte is taken, the sample is
// rebuilt and written back in the compute stage, then held in the output register.
// Reset clears control state only; the line store is not cleared, the first row
// forces the up bytes to zero. A stalled output keeps two bytes (compute stage and
// output register) before the input side is held off.
module png_scanline_unfilter_unit #(
  parameter int unsigned MAX_WIDTH = pus_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pus_pkg::WIDTH_W-1:0] cfg_wdata_i,
  pus_in_if.sink                      in_i,
  pus_out_if.source                   out_o
);
  import pus_pkg::*;

  localparam int unsigned LINE_STORE = MAX_WIDTH * BYTES_PER_PIXEL;
  localparam int unsigned ADDR_W     = $clog2(LINE_STORE);

  // Compute-stage payload
  typedef struct packed {
    logic              err;
    filter_e           filt;
    logic              first_row;
    logic              last;
    logic              line_head;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } s1_t;

  // Line length register, clamped at write
  logic [LEN_W-1:0] line_len_q;
  logic [LEN_W-1:0] width_clamp;
  logic [LEN_W-1:0] line_len_d;

  always_comb begin
    width_clamp = LEN_W'(cfg_wdata_i);
    if (width_clamp == '0) begin
      width_clamp = LEN_W'(1);
    end
    if (width_clamp > LEN_W'(MAX_WIDTH)) begin
      width_clamp = LEN_W'(MAX_WIDTH);
    end
    line_len_d = LEN_W'(width_clamp * BYTES_PER_PIXEL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= LEN_W'(BYTES_PER_PIXEL);
    end else if (cfg_we_i) begin
      line_len_q <= line_len_d;
    end
  end

  // Handshake and stage movement
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_move, in_ready, in_fire;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_move  = s1_valid_q && out_free;
  assign in_ready = !s1_valid_q || s1_move;
  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Line control state, updated as a byte is taken
  logic             first_row_q, first_row_d;
  logic             expect_q, expect_d;
  logic             halted_q, halted_d;
  logic [POS_W-1:0] pos_q, pos_d;
  filter_e          filter_q, filter_d;
  logic             first_eff, expect_eff, halted_eff;
  logic [POS_W-1:0] pos_eff;
  logic             emit;
  s1_t              s1_new;
  s1_t              s1_q;

  always_comb begin
    first_eff  = in_i.new_image ? 1'b1 : first_row_q;
    expect_eff = in_i.new_image ? 1'b1 : expect_q;
    halted_eff = in_i.new_image ? 1'b0 : halted_q;
    pos_eff    = in_i.new_image ? '0 : pos_q;

    first_row_d = first_row_q;
    expect_d    = expect_q;
    halted_d    = halted_q;
    pos_d       = pos_q;
    filter_d    = filter_q;
    emit        = 1'b0;

    s1_new.err       = 1'b0;
    s1_new.filt      = filter_q;
    s1_new.first_row = first_eff;
    s1_new.last      = (({1'b0, pos_eff}) + LEN_W'(1)) >= line_len_q;
    s1_new.line_head = pos_eff < POS_W'(BYTES_PER_PIXEL);
    s1_new.addr      = ADDR_W'(pos_eff);
    s1_new.data      = in_i.filtered_byte;

    if (in_fire) begin
      first_row_d = first_eff;
      expect_d    = expect_eff;
      halted_d    = halted_eff;
      pos_d       = pos_eff;
      if (!halted_eff) begin
        if (expect_eff) begin
          if (in_i.filtered_byte > MAX_FILTER) begin
            // bad filter type: one error result, then halt
            halted_d   = 1'b1;
            emit       = 1'b1;
            s1_new.err = 1'b1;
          end else begin
            filter_d = filter_e'(in_i.filtered_byte[2:0]);
            expect_d = 1'b0;
            pos_d    = '0;
          end
        end else begin
          emit = 1'b1;
          if (s1_new.last) begin
            expect_d    = 1'b1;
            first_row_d = 1'b0;
            pos_d       = '0;
          end else begin
            pos_d = POS_W'(pos_eff + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_row_q <= 1'b1;
      expect_q    <= 1'b1;
      halted_q    <= 1'b0;
      pos_q       <= '0;
      filter_q    <= FILT_NONE;
    end else begin
      first_row_q <= first_row_d;
      expect_q    <= expect_d;
      halted_q    <= halted_d;
      pos_q       <= pos_d;
      filter_q    <= filter_d;
    end
  end

  // Line store: read as a byte is taken, written when the sample leaves compute
  logic [BYTE_W-1:0] line_mem [LINE_STORE];
  logic [BYTE_W-1:0] up_rd_q;
  logic [BYTE_W-1:0] recon;
  logic              mem_we;

  assign mem_we = s1_move && !s1_q.err;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_q.addr] <= recon;
    end
    if (in_fire) begin
      up_rd_q <= line_mem[s1_new.addr];
    end
  end

  // Compute stage register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (emit) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_q <= s1_new;
    end
  end

  // Reconstruction: left, up and upper-left bytes, then the filter
  logic [31:0]       left_q;
  logic [31:0]       upleft_q;
  logic [BYTE_W-1:0] ba, bb, bc, pred;
  logic [BYTE_W:0]   avg_sum;
  logic [9:0]        pa, pb, pc;

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    abs10 = v[9] ? 10'(-v) : 10'(v);
  endfunction

  always_comb begin
    ba = s1_q.line_head ? '0 : left_q[31:24];
    bc = s1_q.line_head ? '0 : upleft_q[31:24];
    bb = s1_q.first_row ? '0 : up_rd_q;

    avg_sum = {1'b0, ba} + {1'b0, bb};
    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    pa = abs10($signed({2'b00, bb}) - $signed({2'b00, bc}));
    pb = abs10($signed({2'b00, ba}) - $signed({2'b00, bc}));
    pc = abs10($signed({2'b00, ba}) + $signed({2'b00, bb}) - $signed({1'b0, bc, 1'b0}));

    case (s1_q.filt)
      FILT_SUB:   pred = ba;
      FILT_UP:    pred = bb;
      FILT_AVG:   pred = avg_sum[BYTE_W:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = ba;
        end else if (pb <= pc) begin
          pred = bb;
        end else begin
          pred = bc;
        end
      end
      default:    pred = '0;
    endcase
    recon = s1_q.data + pred;
  end

  // Left and upper-left history, shifted as each sample commits
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      left_q   <= {left_q[23:0], recon};
      upleft_q <= {upleft_q[23:0], bb};
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (s1_move) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  logic [BYTE_W-1:0] pixel_q;
  logic              eol_q;
  logic              bad_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      pixel_q <= s1_q.err ? '0 : recon;
      eol_q   <= s1_q.err ? 1'b0 : s1_q.last;
      bad_q   <= s1_q.err;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_byte  = pixel_q;
  assign out_o.end_of_line = eol_q;
  assign out_o.bad_filter  = bad_q;

  // Checks
  // a line-store read for a data byte outside the first row never hits the entry being written back in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && in_fire && emit && !s1_new.err && !s1_new.first_row)
      |-> (s1_new.addr != s1_q.addr))
    else $error("line store read collides with pending write-back");

  // a bad filter byte taken leaves the block halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && s1_new.err) |=> halted_q)
    else $error("bad filter did not halt");

  // with both stages full and the output stalled, no byte is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while pipeline is full");

endmodule
